// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl of page_residency_tracker_unit
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_CLK_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// ===== rtl/prt_pkg.sv =====
// types and constants of the page residency tracker
// no dependencies
`default_nettype none
package prt_pkg;
    localparam int unsigned PageW = 52;
    localparam int unsigned RegionW = 46;
    localparam int unsigned CfgW = 32;
    // slots per slice and group count are powers of two so wraps are masks
    localparam int unsigned SlotsPerSlice = 1024;
    localparam int unsigned Groups = 128;
    localparam logic [1:0] CmdQuery = 2'd0;
    localparam logic [1:0] CmdAccess = 2'd1;
    localparam logic [1:0] CmdTick = 2'd2;
    localparam logic [1:0] CfgEnable = 2'd0;
    localparam logic [1:0] CfgPeriod = 2'd1;
    localparam logic [1:0] CfgInterval = 2'd2;
    typedef struct packed {
        logic [1:0]       cmd;
        logic [PageW-1:0] page_number;
    } t_in;
    typedef struct packed {
        logic resident;
        logic cache_hit;
    } t_out;
endpackage
`default_nettype wire

// ===== rtl/prt_ram.sv =====
// generic single port ram with registered read
// no dependencies
`default_nettype none
module prt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/page_residency_tracker_unit.sv =====
// Page residency tracker. Input: cmd/page via valid/ready; output: resident,
// cache_hit via valid/ready with one output register. Config: write port.
// After reset the slot store is cleared by a pass over all GROUPS*SLICES*SLOTS
// entries (1310720 with defaults), ready is low throughout; the per-group slice
// and rotation time store is cleared in the same pass.
// A tick goes straight to the result. A cache hit is found by searching the
// cache one entry a cycle. A miss runs the hash through one shared 32x17
// multiplier, takes the magnitude and reads the group's slice and rotation
// time, then probes each slot with a RAM read: up to 20 probes in each of 10
// slices (5 for an access), 20 more probes to claim a slot, and a rotation
// clears one slice slot by slot (at most two rotations per item).
// One item is worked on at a time; ready is low from acceptance until the
// result has been taken, so a stalled receiver holds the block.
// Depends on prt_pkg, prt_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module page_residency_tracker_unit #(
    parameter int unsigned CACHE_ENTRIES = 25,
    parameter int unsigned PROBE_LIMIT = 20,
    parameter int unsigned SLICES = 10
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire prt_pkg::t_in              i_data,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output prt_pkg::t_out                  o_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_index,
    input  wire logic [prt_pkg::CfgW-1:0]  i_cfg_wdata
);
    localparam int unsigned CeW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned SlW = $clog2(prt_pkg::SlotsPerSlice);
    localparam int unsigned ScW = $clog2(SLICES);
    localparam int unsigned GrW = $clog2(prt_pkg::Groups);
    localparam int unsigned TOTAL = prt_pkg::Groups * SLICES * prt_pkg::SlotsPerSlice;
    localparam int unsigned AdW = $clog2(TOTAL);
    localparam int unsigned PrW = $clog2(PROBE_LIMIT + 1);
    localparam int unsigned EntW = 1 + prt_pkg::RegionW + 64;
    localparam int unsigned GrpW = ScW + 32;

    localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_CACHE = 5'd2,
        S_H0 = 5'd3, S_H1 = 5'd4, S_H2 = 5'd5, S_H3 = 5'd6, S_AGE = 5'd7,
        S_PRD = 5'd8, S_PCHK = 5'd9, S_MRD = 5'd10, S_MCHK = 5'd11,
        S_ROT = 5'd12, S_OUT = 5'd13, S_WAIT = 5'd14, S_ABS = 5'd15,
        S_GRD = 5'd16;

    logic [4:0] r_st;
    logic r_en;
    logic [31:0] r_period;
    logic [16:0] r_intv;
    logic [15:0] r_acnt;
    logic [31:0] r_now;
    logic [prt_pkg::PageW-1:0] r_cache [CACHE_ENTRIES];
    logic [CeW-1:0] r_wptr, r_ci;
    logic [ScW-1:0] r_curg;
    prt_pkg::t_in r_in;
    prt_pkg::t_out r_out;
    logic [31:0] r_prod;
    logic [1:0] r_hstep;
    logic [SlW-1:0] r_start;
    logic [GrW-1:0] r_g;
    logic [ScW-1:0] r_si, r_slice;
    logic [PrW-1:0] r_pi;
    logic r_half, r_retry, r_rotmark;
    logic [AdW:0] r_clr;
    logic [SlW:0] r_rc;

    logic mem_we;
    logic [AdW-1:0] mem_addr;
    logic [EntW-1:0] mem_wd, mem_rd;

    logic grp_we;
    logic [GrW-1:0] grp_addr;
    logic [GrpW-1:0] grp_wd, grp_rd;

    prt_ram #(.WIDTH(EntW), .DEPTH(TOTAL)) u_slots (
        .i_clk(i_clk), .i_we(mem_we), .i_addr(mem_addr),
        .i_wdata(mem_wd), .o_rdata(mem_rd)
    );

    // per group: current slice and time of last rotation
    prt_ram #(.WIDTH(GrpW), .DEPTH(prt_pkg::Groups)) u_groups (
        .i_clk(i_clk), .i_we(grp_we), .i_addr(grp_addr),
        .i_wdata(grp_wd), .o_rdata(grp_rd)
    );

    wire [prt_pkg::RegionW-1:0] region = r_in.page_number[prt_pkg::PageW-1:6];
    wire [5:0] off = r_in.page_number[5:0];
    wire [63:0] obit = 64'd1 << off;
    wire [63:0] rext = {18'd0, region};
    wire [15:0] hfac = (r_hstep == 2'd0) ? rext[31:16] :
                       (r_hstep == 2'd1) ? rext[47:32] : rext[63:48];
    wire [15:0] hadd = (r_hstep == 2'd0) ? 16'd11 : (r_hstep == 2'd1) ? 16'd13 : 16'd17;
    wire [31:0] hmul = r_prod * ({16'd0, hfac} + {16'd0, hadd});
    wire [31:0] habs = r_prod[31] ? (32'd0 - r_prod) : r_prod;

    // slot address of current probe
    wire [SlW:0] psum = {1'b0, r_start} + {{(SlW+1-PrW){1'b0}}, r_pi};
    wire [SlW-1:0] pslot = psum[SlW-1:0];
    wire [AdW-1:0] gbase = AdW'((AdW+1)'(r_g) * (AdW+1)'(SLICES));
    wire [AdW-1:0] paddr = AdW'((gbase + AdW'(r_slice)) * AdW'(prt_pkg::SlotsPerSlice)
                                + AdW'(pslot));
    wire [ScW-1:0] cur_g = r_curg;
    wire [ScW:0] ssum = {1'b0, cur_g} + {1'b0, r_si};
    wire [ScW-1:0] spos = (ssum >= (ScW+1)'(SLICES)) ? ScW'(ssum - (ScW+1)'(SLICES))
                                                      : ScW'(ssum);
    wire [ScW-1:0] nxt_cur = (cur_g == ScW'(SLICES - 1)) ? '0 : cur_g + 1'b1;
    wire [AdW-1:0] raddr = AdW'((gbase + AdW'(nxt_cur)) * AdW'(prt_pkg::SlotsPerSlice)
                                + AdW'(r_rc[SlW-1:0]));
    wire [ScW-1:0] nsl = r_half ? ScW'(SLICES / 2) : ScW'(SLICES);
    wire rot_last = (r_rc == (SlW+1)'(prt_pkg::SlotsPerSlice - 1));

    wire m_valid = mem_rd[EntW-1];
    wire [prt_pkg::RegionW-1:0] m_reg = mem_rd[63+prt_pkg::RegionW:64];
    wire [63:0] m_bm = mem_rd[63:0];

    wire [ScW-1:0] g_cur = grp_rd[GrpW-1:32];
    wire [31:0] g_last = grp_rd[31:0];

    wire in_acc = i_valid && o_ready;
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_WAIT);
    assign o_data = r_out;

    wire [16:0] cfg_iv0 = (i_cfg_wdata[16:0] == 17'd0) ? 17'd1 : i_cfg_wdata[16:0];
    wire [16:0] cfg_iv = (cfg_iv0 > 17'd65536) ? 17'd65536 : cfg_iv0;
    wire [16:0] acnt_inc = {1'b0, r_acnt} + 17'd1;

    always_comb begin
        grp_we = 1'b0;
        grp_addr = r_g;
        grp_wd = {nxt_cur, r_now};
        if (r_st == S_CLR) begin
            grp_we = 1'b1;
            grp_addr = r_clr[GrW-1:0];
            grp_wd = '0;
        end else if (r_st == S_ROT && rot_last) begin
            grp_we = 1'b1;
        end
    end

    always_comb begin
        mem_we = 1'b0;
        mem_addr = paddr;
        mem_wd = '0;
        case (r_st)
            S_CLR: begin
                mem_we = 1'b1;
                mem_addr = r_clr[AdW-1:0];
            end
            S_ROT: begin
                mem_we = 1'b1;
                mem_addr = raddr;
            end
            S_PCHK: begin
                if (m_valid && m_reg == region && !(m_bm[off])) begin
                    mem_we = 1'b1;
                    mem_wd = {1'b1, region, m_bm | obit};
                end
            end
            S_MCHK: begin
                if (!m_valid) begin
                    mem_we = 1'b1;
                    mem_wd = {1'b1, region, obit};
                end else if (m_reg == region) begin
                    mem_we = 1'b1;
                    mem_wd = {1'b1, region, m_bm | obit};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_en <= 1'b1;
            r_period <= 32'd90000;
            r_intv <= 17'd2048;
            r_acnt <= '0;
            r_now <= '0;
            r_wptr <= '0;
            r_clr <= '0;
            for (int i = 0; i < CACHE_ENTRIES; i++) r_cache[i] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    prt_pkg::CfgEnable: r_en <= i_cfg_wdata[0];
                    prt_pkg::CfgPeriod: r_period <= i_cfg_wdata;
                    prt_pkg::CfgInterval: begin
                        r_intv <= cfg_iv;
                        if ({1'b0, r_acnt} >= cfg_iv) r_acnt <= '0;
                    end
                    default: ;
                endcase
            end
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AdW+1)'(TOTAL - 1)) r_st <= S_IDLE;
                end
                S_IDLE: if (in_acc) begin
                    r_in <= i_data;
                    r_ci <= '0;
                    r_half <= (i_data.cmd == prt_pkg::CmdAccess);
                    if (i_data.cmd == prt_pkg::CmdTick) begin
                        r_out <= '0;
                        r_now <= r_now + 1'b1;
                        r_st <= S_WAIT;
                    end else if (i_data.cmd == prt_pkg::CmdQuery && !r_en) begin
                        r_out <= '{resident: 1'b1, cache_hit: 1'b0};
                        r_st <= S_WAIT;
                    end else if (i_data.cmd == prt_pkg::CmdQuery
                                 || i_data.cmd == prt_pkg::CmdAccess) begin
                        r_out <= '0;
                        r_st <= r_en ? S_CACHE : S_WAIT;
                    end else begin
                        r_out <= '0;
                        r_st <= S_WAIT;
                    end
                end
                S_CACHE: begin
                    if (r_cache[r_ci] == r_in.page_number) begin
                        r_out <= '{resident: (r_in.cmd == prt_pkg::CmdQuery),
                                   cache_hit: 1'b1};
                        r_st <= S_WAIT;
                    end else if (r_ci == CeW'(CACHE_ENTRIES - 1)) begin
                        r_prod <= 32'd7 + {16'd0, rext[15:0]};
                        r_hstep <= '0;
                        r_st <= S_H0;
                    end else r_ci <= r_ci + 1'b1;
                end
                S_H0: begin
                    r_prod <= hmul;
                    r_hstep <= r_hstep + 1'b1;
                    if (r_hstep == 2'd2) r_st <= S_ABS;
                end
                S_ABS: begin
                    r_start <= habs[SlW-1:0];
                    r_g <= habs[GrW-1:0];
                    r_st <= S_GRD;
                end
                // group store read for the new group
                S_GRD: r_st <= S_AGE;
                S_AGE: begin
                    r_curg <= g_cur;
                    r_rotmark <= 1'b0;
                    r_retry <= 1'b0;
                    if (r_acnt == 16'd0 && (r_now - g_last) > r_period) begin
                        r_rc <= '0;
                        r_rotmark <= 1'b1;
                        r_st <= S_ROT;
                    end else begin
                        r_si <= '0;
                        r_pi <= '0;
                        r_st <= S_H1;
                    end
                    r_acnt <= (acnt_inc >= r_intv) ? 16'd0 : acnt_inc[15:0];
                end
                S_H1: begin
                    // choose slice to probe
                    r_slice <= spos;
                    r_st <= S_H2;
                end
                S_H2: r_st <= S_PCHK;
                S_PCHK: begin
                    if (!m_valid) begin
                        r_pi <= '0;
                        r_si <= r_si + 1'b1;
                        r_st <= (r_si + 1'b1 == nsl) ? S_H3 : S_H1;
                    end else if (m_reg == region) begin
                        r_out.resident <= (r_in.cmd == prt_pkg::CmdQuery) && m_bm[off];
                        r_st <= S_OUT;
                    end else if (r_pi == PrW'(PROBE_LIMIT - 1)) begin
                        r_pi <= '0;
                        r_si <= r_si + 1'b1;
                        r_st <= (r_si + 1'b1 == nsl) ? S_H3 : S_H1;
                    end else begin
                        r_pi <= r_pi + 1'b1;
                        r_st <= S_H2;
                    end
                end
                S_H3: begin
                    r_slice <= cur_g;
                    r_pi <= '0;
                    r_st <= S_MRD;
                end
                S_MRD: r_st <= S_MCHK;
                S_MCHK: begin
                    if (!m_valid || m_reg == region) r_st <= S_OUT;
                    else if (r_pi == PrW'(PROBE_LIMIT - 1)) begin
                        if (r_retry) r_st <= S_OUT;
                        else begin
                            r_rc <= '0;
                            r_st <= S_ROT;
                        end
                    end else begin
                        r_pi <= r_pi + 1'b1;
                        r_st <= S_MRD;
                    end
                end
                S_ROT: begin
                    r_rc <= r_rc + 1'b1;
                    if (rot_last) begin
                        r_curg <= nxt_cur;
                        if (r_rotmark) begin
                            r_rotmark <= 1'b0;
                            r_si <= '0;
                            r_pi <= '0;
                            r_st <= S_H1;
                        end else begin
                            r_retry <= 1'b1;
                            r_st <= S_H3;
                        end
                    end
                end
                S_OUT: begin
                    if (r_in.cmd == prt_pkg::CmdAccess) begin
                        r_cache[r_wptr] <= r_in.page_number;
                        r_wptr <= (r_wptr == CeW'(CACHE_ENTRIES - 1)) ? '0 : r_wptr + 1'b1;
                    end
                    r_st <= S_WAIT;
                end
                S_WAIT: if (i_ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_rdy_vld_excl, i_clk, i_rst_n, !(o_ready && o_valid), "ready and valid together")
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_data)), "result dropped")
    `ASSERT_CLK(a_acc_res, i_clk, i_rst_n, (o_valid && o_data.resident && !o_data.cache_hit) |-> (r_in.cmd == prt_pkg::CmdQuery), "access resident")
endmodule
`default_nettype wire

// ===== verif/tb_page_residency_tracker_unit.sv =====
// testbench for page_residency_tracker_unit: directed table then random traffic,
// each result checked against a table value or a cycle-free tracker predictor
// depends on prt_pkg and the rtl of page_residency_tracker_unit
`timescale 1ns / 100ps
module tb_page_residency_tracker_unit;

    localparam int NCache = 25;
    localparam int NSlots = 1024;
    localparam int NProbe = 20;
    localparam int NSlices = 10;
    localparam int NGroups = 128;
    localparam int StallLimit = 8000000;
    localparam logic [1:0] CmdSpare = 2'd3;
    localparam logic [1:0] CfgSpare = 2'd3;

    typedef struct {
        logic [1:0]  cmd;
        logic [51:0] page;
        bit          typed;
        bit          res;
        bit          hit;
    } t_row;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    prt_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_ready;
    prt_pkg::t_out o_data;
    logic          i_cfg_we;
    logic [1:0]    i_cfg_index;
    logic [prt_pkg::CfgW-1:0] i_cfg_wdata;

    page_residency_tracker_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata)
    );

    // tracker state as predicted
    bit          trk_enable;
    bit [31:0]   trk_period;
    int          trk_interval;
    bit [51:0]   recent[NCache];
    int          recent_ptr;
    bit [45:0]   slot_region[int];
    bit [63:0]   slot_bits[int];
    int          cur_slice[NGroups];
    bit [31:0]   last_rot[NGroups];
    int          access_cnt;
    bit [31:0]   now_ms;

    prt_pkg::t_out expected_q[$];
    bit [45:0]   collide_pool[$];
    bit [51:0]   hot_pages[8];
    int          mismatches;
    int          results_seen;
    int          rotations;
    int          stall_cycles;
    bit          no_idle;
    int          rx_hold;

    function automatic bit [9:0] start_slot(bit [45:0] r);
        bit [31:0] p;
        p = 32'd7 + r[15:0];
        p = p * (32'd11 + r[31:16]);
        p = p * (32'd13 + r[45:32]);
        p = p * 32'd17;
        if (p[31])
            p = -p;
        return p[9:0];
    endfunction

    function automatic int slot_base(int g, int s);
        return (g * NSlices + s) * NSlots;
    endfunction

    function automatic int locate(int base, int start, bit [45:0] r, bit add);
        int idx;
        for (int i = 0; i < NProbe; i++) begin
            idx = base + (start + i) % NSlots;
            if (!slot_region.exists(idx)) begin
                if (!add)
                    return -1;
                slot_region[idx] = r;
                slot_bits[idx] = '0;
                return idx;
            end
            if (slot_region[idx] == r)
                return idx;
        end
        return -1;
    endfunction

    function automatic bit set_bit(int base, int start, bit [45:0] r, int off);
        int s;
        s = locate(base, start, r, 1'b1);
        if (s < 0)
            return 1'b0;
        slot_bits[s][off] = 1'b1;
        return 1'b1;
    endfunction

    function automatic void advance_slice(int g);
        int base;
        cur_slice[g] = (cur_slice[g] + 1) % NSlices;
        base = slot_base(g, cur_slice[g]);
        for (int i = 0; i < NSlots; i++) begin
            if (slot_region.exists(base + i)) begin
                slot_region.delete(base + i);
                slot_bits.delete(base + i);
            end
        end
        last_rot[g] = now_ms;
        rotations++;
    endfunction

    function automatic bit region_lookup(bit [45:0] r, int off, bit half);
        int start;
        int g;
        int n;
        int s;
        bit [31:0] age;
        start = start_slot(r);
        g = start % NGroups;
        n = half ? NSlices / 2 : NSlices;
        age = now_ms - last_rot[g];
        if (access_cnt == 0 && age > trk_period)
            advance_slice(g);
        access_cnt++;
        if (access_cnt >= trk_interval)
            access_cnt = 0;
        for (int i = 0; i < n; i++) begin
            s = locate(slot_base(g, (cur_slice[g] + i) % NSlices), start, r, 1'b0);
            if (s >= 0) begin
                if (slot_bits[s][off])
                    return 1'b1;
                slot_bits[s][off] = 1'b1;
                return 1'b0;
            end
        end
        if (!set_bit(slot_base(g, cur_slice[g]), start, r, off)) begin
            advance_slice(g);
            void'(set_bit(slot_base(g, cur_slice[g]), start, r, off));
        end
        return 1'b0;
    endfunction

    function automatic bit in_recent(bit [51:0] pg);
        for (int i = 0; i < NCache; i++)
            if (recent[i] == pg)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic prt_pkg::t_out predict_result(logic [1:0] cmd, logic [51:0] pg);
        prt_pkg::t_out r;
        r = '0;
        if (cmd == prt_pkg::CmdTick) begin
            now_ms++;
        end else if (cmd == prt_pkg::CmdQuery) begin
            if (!trk_enable) begin
                r.resident = 1'b1;
            end else if (in_recent(pg)) begin
                r.resident = 1'b1;
                r.cache_hit = 1'b1;
            end else begin
                r.resident = region_lookup(pg[51:6], pg[5:0], 1'b0);
            end
        end else if (cmd == prt_pkg::CmdAccess && trk_enable) begin
            if (in_recent(pg)) begin
                r.cache_hit = 1'b1;
            end else begin
                void'(region_lookup(pg[51:6], pg[5:0], 1'b1));
                recent[recent_ptr] = pg;
                recent_ptr = (recent_ptr + 1) % NCache;
            end
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(50, 300);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= StallLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver side stalls
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold <= rx_hold - 1;
            end else begin
                i_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    rx_hold <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        prt_pkg::t_out want;
        if (o_valid && i_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %b", o_data);
            end else begin
                want = expected_q.pop_front();
                if (o_data.resident !== want.resident || o_data.cache_hit !== want.cache_hit)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result %0d: expected resident %b hit %b, got %b %b",
                                 results_seen, want.resident, want.cache_hit,
                                 o_data.resident, o_data.cache_hit);
                end
            end
        end
    end

    task automatic send_item(logic [1:0] cmd, logic [51:0] pg, bit typed, bit res, bit hit);
        int g;
        prt_pkg::t_out pred;
        g = pick_gap();
        if (g > 0) begin
            i_valid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data.cmd = cmd;
        i_data.page_number = pg;
        do @(posedge i_clk); while (!o_ready);
        pred = predict_result(cmd, pg);
        if (typed) begin
            pred.resident = res;
            pred.cache_hit = hit;
        end
        expected_q.push_back(pred);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        bit [16:0] v;
        drain();
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            prt_pkg::CfgEnable: trk_enable = val[0];
            prt_pkg::CfgPeriod: trk_period = val;
            prt_pkg::CfgInterval: begin
                v = val[16:0];
                trk_interval = (v == 0) ? 1 : (v > 65536) ? 65536 : v;
                if (access_cnt >= trk_interval)
                    access_cnt = 0;
            end
            default: ;
        endcase
    endtask

    task automatic random_burst(int count);
        logic [1:0] cmd;
        logic [51:0] pg;
        int r;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // sender holds off until the block has caught up
            if (k % 400 == 399)
                drain();
            r = $urandom_range(0, 99);
            cmd = (r < 10) ? prt_pkg::CmdTick : (r < 13) ? CmdSpare :
                  (r < 55) ? prt_pkg::CmdQuery : prt_pkg::CmdAccess;
            r = $urandom_range(0, 99);
            if (r < 35)
                pg = {collide_pool[$urandom_range(0, collide_pool.size() - 1)],
                      6'($urandom_range(0, 7))};
            else if (r < 60)
                pg = hot_pages[$urandom_range(0, 7)];
            else if (r < 72)
                pg = recent[$urandom_range(0, NCache - 1)];
            else if (r < 82)
                pg = 52'($urandom_range(0, 511));
            else
                pg = {20'($urandom), $urandom};
            send_item(cmd, pg, 1'b0, 1'b0, 1'b0);
        end
    endtask

    initial begin
        t_row table_rows[$];
        bit [45:0] reg_try;
        bit [9:0]  target;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = prt_pkg::CfgEnable;
        i_cfg_wdata = '0;
        stall_cycles = 0;
        rx_hold = 0;
        mismatches = 0;
        results_seen = 0;
        rotations = 0;
        no_idle = 1'b0;
        trk_enable = 1'b1;
        trk_period = 32'd90000;
        trk_interval = 2048;
        recent_ptr = 0;
        access_cnt = 0;
        now_ms = '0;
        foreach (recent[i]) recent[i] = '0;
        foreach (cur_slice[i]) begin
            cur_slice[i] = 0;
            last_rot[i] = '0;
        end
        // regions sharing one start slot, enough to overflow a chain
        target = start_slot(46'h1);
        collide_pool.push_back(46'h1);
        while (collide_pool.size() < 24) begin
            reg_try = {14'($urandom), $urandom};
            if (start_slot(reg_try) == target)
                collide_pool.push_back(reg_try);
        end
        foreach (hot_pages[i])
            hot_pages[i] = {20'($urandom), $urandom};

        table_rows.push_back('{prt_pkg::CmdQuery, 52'h0, 1, 1, 1});
        table_rows.push_back('{prt_pkg::CmdAccess, 52'h0, 1, 0, 1});
        table_rows.push_back('{prt_pkg::CmdTick, 52'hF_FFFF_FFFF_FFFF, 1, 0, 0});
        table_rows.push_back('{CmdSpare, 52'hF_FFFF_FFFF_FFFF, 1, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'hF_FFFF_FFFF_FFFF, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdAccess, 52'hF_FFFF_FFFF_FFFF, 1, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'hF_FFFF_FFFF_FFFF, 1, 1, 1});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'h40, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'h40, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'h3F, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'h3F, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdAccess, 52'hA_AAAA_AAAA_AAAA, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdQuery, 52'h5_5555_5555_5555, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdAccess, 52'h5_5555_5555_5555, 0, 0, 0});
        table_rows.push_back('{prt_pkg::CmdAccess, 52'h5_5555_5555_5555, 1, 0, 1});
        table_rows.push_back('{prt_pkg::CmdTick, 52'h0, 1, 0, 0});

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (table_rows[i])
            send_item(table_rows[i].cmd, table_rows[i].page, table_rows[i].typed,
                      table_rows[i].res, table_rows[i].hit);
        random_burst(500);

        // tracking off: fixed answers, ticks still count
        write_reg(prt_pkg::CfgEnable, 32'd0);
        send_item(prt_pkg::CmdQuery, 52'h123, 1, 1, 0);
        send_item(prt_pkg::CmdAccess, 52'h123, 1, 0, 0);
        random_burst(150);
        write_reg(prt_pkg::CfgEnable, 32'd1);

        // age checked on every cache miss, any elapsed tick rotates
        write_reg(prt_pkg::CfgPeriod, 32'd0);
        write_reg(prt_pkg::CfgInterval, 32'd1);
        random_burst(350);

        write_reg(prt_pkg::CfgPeriod, 32'hFFFF_FFFF);
        write_reg(prt_pkg::CfgInterval, 32'h0001_FFFF);
        random_burst(200);

        write_reg(prt_pkg::CfgInterval, 32'd0);
        write_reg(prt_pkg::CfgPeriod, 32'd3);
        write_reg(CfgSpare, 32'hFFFF_FFFF);
        random_burst(250);

        write_reg(prt_pkg::CfgInterval, 32'd7);
        write_reg(prt_pkg::CfgPeriod, 32'd40);
        random_burst(250);

        drain();
        repeat (20) @(negedge i_clk);
        $display("%0d results checked, %0d slice rotations predicted, %0d mismatches",
                 results_seen, rotations, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
